// ----- hw/rtl/ucld_pkg.sv -----
// ----------------------------------------------------------------------------
// ucld_pkg
// shared constants, types and keyword table for the command line decoder
// ----------------------------------------------------------------------------
package ucld_pkg;

    // default line length limit
    localparam int LINE_LIMIT_DEF = 29;

    // result field widths
    localparam int ACT_W  = 3;
    localparam int KEPT_W = 5;

    // keyword table geometry
    localparam int NUM_KEYS = 6;
    localparam int KEY_MAX  = 9;
    localparam int POS_W    = 4;

    // action codes
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_SET   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_RUN   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_PAUSE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_STOP  = 3'd4;
    localparam logic [ACT_W-1:0] ACT_RTC   = 3'd5;

    // keyword indexes
    localparam logic [2:0] KEY_SWTSET    = 3'd0;
    localparam logic [2:0] KEY_SWTSTART  = 3'd1;
    localparam logic [2:0] KEY_SWTSTOP   = 3'd2;
    localparam logic [2:0] KEY_SWTPAUSE  = 3'd3;
    localparam logic [2:0] KEY_SWTRESUME = 3'd4;
    localparam logic [2:0] KEY_SETRTC    = 3'd5;

    // character codes
    localparam logic [7:0] CH_BS      = 8'd8;
    localparam logic [7:0] CH_TAB     = 8'd9;
    localparam logic [7:0] CH_CR      = 8'd13;
    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_DIGIT0  = 8'd48;
    localparam logic [7:0] CH_DIGIT9  = 8'd57;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_UPPER_A = 8'd65;
    localparam logic [7:0] CH_UPPER_Z = 8'd90;
    localparam logic [7:0] CH_LOWER_A = 8'd97;
    localparam logic [7:0] CH_LOWER_Z = 8'd122;
    localparam logic [7:0] CH_DEL     = 8'd127;
    localparam logic [7:0] CH_CASE_OFS = 8'd32;

    // matcher control and status
    typedef struct packed {
        logic       clear;
        logic       char_valid;
        logic [7:0] char_code;
    } t_match_ctl;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [KEPT_W-1:0] kept;
    } t_match_res;

    function automatic logic [POS_W-1:0] key_len(input logic [2:0] k);
        logic [POS_W-1:0] len;
        case (k)
            KEY_SWTSET:    len = 4'd6;
            KEY_SWTSTART:  len = 4'd8;
            KEY_SWTSTOP:   len = 4'd7;
            KEY_SWTPAUSE:  len = 4'd8;
            KEY_SWTRESUME: len = 4'd9;
            KEY_SETRTC:    len = 4'd6;
            default:       len = 4'd0;
        endcase
        return len;
    endfunction

    function automatic logic [ACT_W-1:0] key_code(input logic [2:0] k);
        logic [ACT_W-1:0] code;
        case (k)
            KEY_SWTSET:    code = ACT_SET;
            KEY_SWTSTART:  code = ACT_RUN;
            KEY_SWTSTOP:   code = ACT_STOP;
            KEY_SWTPAUSE:  code = ACT_PAUSE;
            KEY_SWTRESUME: code = ACT_RUN;
            KEY_SETRTC:    code = ACT_RTC;
            default:       code = ACT_NONE;
        endcase
        return code;
    endfunction

    // character p of keyword k, first character at p = 0
    function automatic logic [7:0] key_char(input logic [2:0] k,
                                            input logic [POS_W-1:0] p);
        logic [KEY_MAX*8-1:0] txt;
        logic [POS_W-1:0]     len;
        logic [7:0]           ch;
        len = key_len(k);
        case (k)
            KEY_SWTSET:    txt = (KEY_MAX*8)'("SWTSET");
            KEY_SWTSTART:  txt = (KEY_MAX*8)'("SWTSTART");
            KEY_SWTSTOP:   txt = (KEY_MAX*8)'("SWTSTOP");
            KEY_SWTPAUSE:  txt = (KEY_MAX*8)'("SWTPAUSE");
            KEY_SWTRESUME: txt = (KEY_MAX*8)'("SWTRESUME");
            KEY_SETRTC:    txt = (KEY_MAX*8)'("SETRTC");
            default:       txt = '0;
        endcase
        if (p < len) begin
            ch = txt[(int'(len) - 1 - int'(p)) * 8 +: 8];
        end else begin
            ch = 8'd0;
        end
        return ch;
    endfunction

endpackage

// ----- hw/rtl/ucld_line_mem.sv -----
// ----------------------------------------------------------------------------
// ucld_line_mem
// line store: one write port, one read port with registered read data
// ----------------------------------------------------------------------------
module ucld_line_mem
    import ucld_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF,
    localparam int AW = $clog2(LINE_LIMIT)
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    output logic [7:0]    o_rd_data
);

    logic [7:0] r_mem [LINE_LIMIT];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- hw/rtl/ucld_kw_match.sv -----
// ----------------------------------------------------------------------------
// ucld_kw_match
// streaming keyword matcher: one stored character per cycle
// ----------------------------------------------------------------------------
module ucld_kw_match
    import ucld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_match_ctl i_ctl,
    output t_match_res o_res
);

    logic [NUM_KEYS-1:0] r_match, n_match;
    logic [POS_W-1:0]    r_pos, n_pos;
    logic                r_digit_seen, n_digit_seen;
    logic [KEPT_W-1:0]   r_kept, n_kept;
    logic                is_blank, is_digit;
    logic [ACT_W-1:0]    action;

    assign is_blank = (i_ctl.char_code == CH_SPACE) || (i_ctl.char_code == CH_TAB);
    assign is_digit = (i_ctl.char_code >= CH_DIGIT0) && (i_ctl.char_code <= CH_DIGIT9);

    always_comb begin
        n_match      = r_match;
        n_pos        = r_pos;
        n_digit_seen = r_digit_seen;
        n_kept       = r_kept;
        if (i_ctl.clear) begin
            n_match      = '1;
            n_pos        = '0;
            n_digit_seen = 1'b0;
            n_kept       = '0;
        end else if (i_ctl.char_valid && !is_blank) begin
            n_kept = r_kept + 1'b1;
            if (!r_digit_seen) begin
                if (is_digit) begin
                    n_digit_seen = 1'b1;
                end else begin
                    for (int k = 0; k < NUM_KEYS; k++) begin
                        n_match[k] = r_match[k] && (r_pos < key_len(3'(k)))
                                     && (i_ctl.char_code == key_char(3'(k), r_pos));
                    end
                    // saturate past the longest keyword
                    if (r_pos <= POS_W'(KEY_MAX)) begin
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match      <= '1;
            r_pos        <= '0;
            r_digit_seen <= 1'b0;
            r_kept       <= '0;
        end else begin
            r_match      <= n_match;
            r_pos        <= n_pos;
            r_digit_seen <= n_digit_seen;
            r_kept       <= n_kept;
        end
    end

    // keyword must match in full length
    always_comb begin
        action = ACT_NONE;
        for (int k = 0; k < NUM_KEYS; k++) begin
            if (r_match[k] && (r_pos == key_len(3'(k)))) begin
                action = key_code(3'(k));
            end
        end
    end

    assign o_res.action = action;
    assign o_res.kept   = r_kept;

endmodule

// ----- hw/rtl/uart_command_line_decoder.sv -----
// ----------------------------------------------------------------------------
// uart_command_line_decoder
// assembles received bytes into a command line and decodes its keyword
// ----------------------------------------------------------------------------
// Every received word yields exactly one result word. A byte that does not end
// a line is answered directly: its result (line_complete 0, other fields 0)
// is in the output register on the next cycle, and a new byte can be taken
// while that result waits, provided it is being drained the same cycle. A byte
// that ends the line (carriage return, or an append that reaches LINE_LIMIT
// characters) starts a walk over the line store: one memory read per stored
// character, through the single read port of the line store. During the walk
// no byte is accepted. Letters are folded to upper case, spaces and tabs are
// dropped, and the characters before the first digit are matched against the
// six keywords. kept_length wraps modulo 32. The line store needs no clearing
// after reset; only entries below the current length are read.
module uart_command_line_decoder
    import ucld_pkg::*;
#(
    parameter int LINE_LIMIT = LINE_LIMIT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // receive side
    input  logic              i_rx_valid,
    output logic              o_rx_ready,
    input  logic [7:0]        i_rx_byte,
    // result side
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output logic              o_line_complete,
    output logic [ACT_W-1:0]  o_action,
    output logic              o_ended_by_limit,
    output logic [KEPT_W-1:0] o_kept_length
);

    localparam int AW = $clog2(LINE_LIMIT);
    localparam int LW = $clog2(LINE_LIMIT + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic              r_state, n_state;
    logic [LW-1:0]     r_len, n_len;
    logic [LW-1:0]     r_walk_len, n_walk_len;
    logic [LW-1:0]     r_rd_idx, n_rd_idx;
    logic              r_rd_pend;
    logic              r_by_limit, n_by_limit;

    // output register
    logic              r_out_valid, n_out_valid;
    logic              r_out_done, n_out_done;
    logic [ACT_W-1:0]  r_out_action, n_out_action;
    logic              r_out_limit, n_out_limit;
    logic [KEPT_W-1:0] r_out_kept, n_out_kept;

    // byte classification
    logic              rx_acc;
    logic              is_erase, is_keep, is_lower, is_append;
    logic [7:0]        app_char;
    logic              hits_limit, line_end;
    logic [LW-1:0]     len_after;

    // walk control
    logic              rd_issue, walk_done;
    logic [7:0]        rd_data;
    t_match_ctl        match_ctl;
    t_match_res        match_res;

    assign o_rx_ready = (r_state == ST_IDLE) && (!r_out_valid || i_res_ready);
    assign rx_acc     = i_rx_valid && o_rx_ready;

    assign is_erase  = (i_rx_byte == CH_DEL) || (i_rx_byte == CH_BS);
    assign is_keep   = ((i_rx_byte >= CH_UPPER_A) && (i_rx_byte <= CH_UPPER_Z))
                    || ((i_rx_byte >= CH_DIGIT0) && (i_rx_byte <= CH_DIGIT9))
                    || (i_rx_byte == CH_SPACE) || (i_rx_byte == CH_TAB)
                    || (i_rx_byte == CH_COLON);
    assign is_lower  = (i_rx_byte >= CH_LOWER_A) && (i_rx_byte <= CH_LOWER_Z);
    assign is_append = is_keep || is_lower;
    assign app_char  = is_lower ? (i_rx_byte - CH_CASE_OFS) : i_rx_byte;

    // the stored length never reaches the limit while idle, so an append
    // always lands inside the store
    assign hits_limit = is_append && (r_len == LW'(LINE_LIMIT - 1));
    assign line_end   = hits_limit || (i_rx_byte == CH_CR);

    always_comb begin
        len_after = r_len;
        if (is_erase) begin
            if (r_len != '0) begin
                len_after = r_len - 1'b1;
            end
        end else if (is_append) begin
            len_after = r_len + 1'b1;
        end
    end

    // walk issues one read per stored character, read data comes back in the next cycle
    assign rd_issue  = (r_state == ST_WALK) && (r_rd_idx != r_walk_len);
    assign walk_done = (r_state == ST_WALK) && !rd_issue && !r_rd_pend;

    ucld_line_mem #(
        .LINE_LIMIT (LINE_LIMIT)
    ) u_line_mem (
        .i_clk     (i_clk),
        .i_wr_en   (rx_acc && is_append),
        .i_wr_addr (r_len[AW-1:0]),
        .i_wr_data (app_char),
        .i_rd_en   (rd_issue),
        .i_rd_addr (r_rd_idx[AW-1:0]),
        .o_rd_data (rd_data)
    );

    assign match_ctl.clear      = rx_acc && line_end;
    assign match_ctl.char_valid = r_rd_pend;
    assign match_ctl.char_code  = rd_data;

    ucld_kw_match u_kw_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (match_ctl),
        .o_res   (match_res)
    );

    always_comb begin
        n_state      = r_state;
        n_len        = r_len;
        n_walk_len   = r_walk_len;
        n_rd_idx     = r_rd_idx;
        n_by_limit   = r_by_limit;
        n_out_valid  = r_out_valid;
        n_out_done   = r_out_done;
        n_out_action = r_out_action;
        n_out_limit  = r_out_limit;
        n_out_kept   = r_out_kept;

        // result taken downstream
        if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (rx_acc) begin
                    if (line_end) begin
                        // line finished: walk the store, then report
                        n_state    = ST_WALK;
                        n_walk_len = len_after;
                        n_rd_idx   = '0;
                        n_by_limit = hits_limit;
                        n_len      = '0;
                    end else begin
                        n_len        = len_after;
                        n_out_valid  = 1'b1;
                        n_out_done   = 1'b0;
                        n_out_action = ACT_NONE;
                        n_out_limit  = 1'b0;
                        n_out_kept   = '0;
                    end
                end
            end
            ST_WALK: begin
                if (rd_issue) begin
                    n_rd_idx = r_rd_idx + 1'b1;
                end
                if (walk_done) begin
                    n_state      = ST_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_done   = 1'b1;
                    n_out_action = match_res.action;
                    n_out_limit  = r_by_limit;
                    n_out_kept   = match_res.kept;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_len       <= '0;
            r_walk_len  <= '0;
            r_rd_idx    <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_walk_len  <= n_walk_len;
            r_rd_idx    <= n_rd_idx;
            r_rd_pend   <= rd_issue;
            r_out_valid <= n_out_valid;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_by_limit   <= n_by_limit;
        r_out_done   <= n_out_done;
        r_out_action <= n_out_action;
        r_out_limit  <= n_out_limit;
        r_out_kept   <= n_out_kept;
    end

    assign o_res_valid      = r_out_valid;
    assign o_line_complete  = r_out_done;
    assign o_action         = r_out_action;
    assign o_ended_by_limit = r_out_limit;
    assign o_kept_length    = r_out_kept;

    // stored length stays below the limit between lines
    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len < LW'(LINE_LIMIT))
        else $error("line length reached the limit while idle");

    // walk never reads past the finished line
    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> (r_rd_idx <= r_walk_len))
        else $error("walk index beyond line length");

    // output register is empty for the whole walk, so the final result fits
    a_walk_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_WALK) |-> !r_out_valid)
        else $error("result pending during walk");

    // a carriage return always starts a walk
    a_cr_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && (i_rx_byte == CH_CR)) |=> (r_state == ST_WALK))
        else $error("carriage return did not end the line");

endmodule

// ----- tb/uart_command_line_decoder_tb.sv -----
// ----------------------------------------------------------------------------
// uart_command_line_decoder_tb
// self-checking bench: serial bytes in, one decoded line result word out per
// byte, compared against a behavioral line assembler and keyword matcher
// ----------------------------------------------------------------------------
module uart_command_line_decoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import ucld_pkg::*;

    localparam int unsigned BYTE_TARGET = 1100;
    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned IDLE_PCT    = 20;

    // one expected result word
    typedef struct packed {
        logic              done;
        logic [ACT_W-1:0]  action;
        logic              by_limit;
        logic [KEPT_W-1:0] kept;
    } t_line_result;

    // line assembler model plus the queue of results still owed by the block
    class line_decode_scoreboard;
        string            commands[NUM_KEYS] = '{"SWTSET", "SWTSTART", "SWTSTOP",
                                                 "SWTPAUSE", "SWTRESUME", "SETRTC"};
        logic [ACT_W-1:0] command_action[NUM_KEYS] = '{ACT_SET, ACT_RUN, ACT_STOP,
                                                       ACT_PAUSE, ACT_RUN, ACT_RTC};
        logic [7:0]       line_chars[LINE_LIMIT_DEF];
        int unsigned      line_len;
        bit               last_done;
        int unsigned      mismatches;
        t_line_result     awaited_lines[$];

        // drop blanks, cut at the first digit, look the rest up as a keyword
        function logic [ACT_W-1:0] match_command(output int unsigned kept_n);
            logic [7:0]       kept[LINE_LIMIT_DEF];
            int unsigned      cut;
            bit               same;
            logic [ACT_W-1:0] act;
            kept_n = 0;
            for (int i = 0; i < int'(line_len); i++) begin
                if (line_chars[i] != CH_SPACE && line_chars[i] != CH_TAB) begin
                    kept[kept_n] = line_chars[i];
                    kept_n++;
                end
            end
            cut = kept_n;
            for (int i = int'(kept_n) - 1; i >= 0; i--) begin
                if (kept[i] >= CH_DIGIT0 && kept[i] <= CH_DIGIT9) cut = i;
            end
            act = ACT_NONE;
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (commands[k].len() == int'(cut)) begin
                    same = 1'b1;
                    for (int i = 0; i < int'(cut); i++) begin
                        if (kept[i] != 8'(commands[k][i])) same = 1'b0;
                    end
                    if (same) act = command_action[k];
                end
            end
            return act;
        endfunction

        // returns 1 when the byte is one the block acts on
        function bit take_rx_byte(input logic [7:0] b);
            t_line_result r;
            logic [7:0]   c;
            bit           app;
            bit           acted;
            int unsigned  kept_n;
            r     = '0;
            c     = b;
            app   = 1'b0;
            acted = 1'b0;
            if (line_len >= LINE_LIMIT_DEF) line_len = 0;
            if (b == CH_DEL || b == CH_BS) begin
                acted = 1'b1;
                if (line_len > 0) line_len--;
            end else if ((b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
                         (b >= CH_DIGIT0 && b <= CH_DIGIT9) ||
                         b == CH_SPACE || b == CH_TAB || b == CH_COLON) begin
                app = 1'b1;
            end else if (b >= CH_LOWER_A && b <= CH_LOWER_Z) begin
                c   = b - CH_CASE_OFS;
                app = 1'b1;
            end
            if (app) begin
                line_chars[line_len] = c;
                line_len++;
                acted = 1'b1;
            end
            if (line_len >= LINE_LIMIT_DEF) begin
                r.done     = 1'b1;
                r.by_limit = 1'b1;
            end else if (b == CH_CR) begin
                r.done = 1'b1;
                acted  = 1'b1;
            end
            if (r.done) begin
                r.action = match_command(kept_n);
                r.kept   = KEPT_W'(kept_n);
                line_len = 0;
            end
            last_done = r.done;
            awaited_lines.push_back(r);
            return acted;
        endfunction

        function void check_line_result(input t_line_result got);
            t_line_result exp;
            if (awaited_lines.size() == 0) begin
                $error("result word with nothing expected: complete %0d action %0d",
                       got.done, got.action);
                mismatches++;
                return;
            end
            exp = awaited_lines.pop_front();
            if (got.done != exp.done) begin
                $error("line_complete: expected %0d, got %0d", exp.done, got.done);
                mismatches++;
            end
            if (got.action != exp.action) begin
                $error("action: expected %0d, got %0d", exp.action, got.action);
                mismatches++;
            end
            if (got.by_limit != exp.by_limit) begin
                $error("ended_by_limit: expected %0d, got %0d", exp.by_limit, got.by_limit);
                mismatches++;
            end
            if (got.kept != exp.kept) begin
                $error("kept_length: expected %0d, got %0d", exp.kept, got.kept);
                mismatches++;
            end
        endfunction

        function int unsigned outstanding();
            return awaited_lines.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_rx_valid = 1'b0;
    logic              o_rx_ready;
    logic [7:0]        i_rx_byte = 8'd0;
    logic              o_res_valid;
    logic              i_res_ready = 1'b0;
    logic              o_line_complete;
    logic [ACT_W-1:0]  o_action;
    logic              o_ended_by_limit;
    logic [KEPT_W-1:0] o_kept_length;

    line_decode_scoreboard sb;
    int unsigned           acted_bytes = 0;
    int unsigned           cycle_count = 0;
    bit                    quiet = 1'b0;    // no idling on either side while set

    uart_command_line_decoder dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_valid       (i_rx_valid),
        .o_rx_ready       (o_rx_ready),
        .i_rx_byte        (i_rx_byte),
        .o_res_valid      (o_res_valid),
        .i_res_ready      (i_res_ready),
        .o_line_complete  (o_line_complete),
        .o_action         (o_action),
        .o_ended_by_limit (o_ended_by_limit),
        .o_kept_length    (o_kept_length)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit, sized far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL uart_command_line_decoder");
            $finish;
        end
    end

    // result side: check each accepted word, then pick the next ready value
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_res_ready <= 1'b0;
        end else begin
            if (o_res_valid && i_res_ready) begin
                sb.check_line_result('{done: o_line_complete, action: o_action,
                                       by_limit: o_ended_by_limit, kept: o_kept_length});
            end
            i_res_ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // upper-case letters come out lower case half the time
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z && $urandom_range(1) == 1)
            return c + CH_CASE_OFS;
        return c;
    endfunction

    // any byte that gets appended to the line
    function automatic logic [7:0] random_fill(input bit with_blanks);
        int unsigned pick;
        pick = $urandom_range(with_blanks ? 9 : 6);
        case (pick)
            0, 1, 2, 3: return fold_case(8'(CH_UPPER_A + $urandom_range(25)));
            4, 5:       return 8'(CH_DIGIT0 + $urandom_range(9));
            6:          return CH_COLON;
            7, 8:       return CH_SPACE;
            default:    return CH_TAB;
        endcase
    endfunction

    // present one byte and hold it until the block takes the word
    task automatic send_byte(input logic [7:0] b);
        if (!quiet) begin
            while ($urandom_range(99) < IDLE_PCT) begin
                i_rx_valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        if (sb.take_rx_byte(b)) acted_bytes++;
    endtask

    // hold off the sender until every owed result word has been drained
    task automatic drain_results();
        i_rx_valid <= 1'b0;
        do @(posedge i_clk); while (sb.outstanding() != 0);
    endtask

    task automatic send_random_line();
        int unsigned kind;
        int unsigned k;
        int unsigned n;
        int unsigned drop;
        string       cmd;
        kind = $urandom_range(99);
        k    = $urandom_range(NUM_KEYS - 1);
        cmd  = sb.commands[k];
        if (kind < 62) begin
            // keyword with blanks, retyped slips, digit suffix, optional colon, carriage return
            for (int i = 0; i < cmd.len(); i++) begin
                if ($urandom_range(99) < 12) send_byte($urandom_range(1) ? CH_SPACE : CH_TAB);
                if ($urandom_range(99) < 5) begin
                    send_byte(random_fill(1'b0));
                    send_byte($urandom_range(1) ? CH_BS : CH_DEL);
                end
                send_byte(fold_case(8'(cmd[i])));
            end
            n = $urandom_range(3);
            for (int i = 0; i < int'(n); i++) begin
                if ($urandom_range(99) < 15) send_byte(CH_SPACE);
                send_byte(8'(CH_DIGIT0 + $urandom_range(9)));
            end
            if ($urandom_range(99) < 6) send_byte(CH_COLON);
            send_byte(CH_CR);
        end else if (kind < 74) begin
            // keyword then padding until the length limit closes the line
            n = $urandom_range(1);
            for (int i = 0; i < cmd.len(); i++) send_byte(fold_case(8'(cmd[i])));
            do send_byte(random_fill(n == 1)); while (!sb.last_done);
        end else if (kind < 87) begin
            // keyword with one character lost or replaced
            drop = $urandom_range(cmd.len() - 1);
            for (int i = 0; i < cmd.len(); i++) begin
                if (i != int'(drop)) send_byte(fold_case(8'(cmd[i])));
                else if ($urandom_range(1) == 1) send_byte(random_fill(1'b1));
            end
            if ($urandom_range(1) == 1) send_byte(random_fill(1'b1));
            send_byte(CH_CR);
        end else begin
            // raw noise over the whole byte range
            n = $urandom_range(1, 12);
            for (int i = 0; i < int'(n); i++) send_byte(8'($urandom_range(255)));
            if ($urandom_range(1) == 1) send_byte(CH_CR);
        end
    endtask

    // opening bytes: erase and ignored codes on an empty line, empty line,
    // mixed case keyword with blanks and a digit, keyword spoiled by a colon
    logic [7:0] opening[$] = '{CH_BS, CH_DEL, 8'hFF, 8'h80, 8'h7E, 8'h00, CH_CR,
                               "s", "W", "t", " ", "S", "e", CH_TAB, "T", "7", CH_CR,
                               "Z", CH_BS, "S", "E", "T", "R", "T", "C", ":", CH_CR};
    bit held_once = 1'b0;

    initial begin
        sb = new;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening[i]) send_byte(opening[i]);
        drain_results();

        while (acted_bytes < BYTE_TARGET) begin
            quiet = (acted_bytes >= 500 && acted_bytes < 700);
            if (!held_once && acted_bytes >= 300) begin
                drain_results();
                held_once = 1'b1;
            end
            send_random_line();
        end
        i_rx_valid <= 1'b0;

        // wait for every owed word, then let the clock run on before the verdict
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (LINE_LIMIT_DEF + 8) @(posedge i_clk);

        if (sb.mismatches == 0) begin
            $display("PASS uart_command_line_decoder");
        end else begin
            $display("FAIL uart_command_line_decoder");
        end
        $finish;
    end

endmodule
